// ===== hw/rtl/sdfe_pkg.sv =====
// ----------------------------------------------------------------------------
// sdfe_pkg: shared definitions for the event stream data field extractor
// Character codes, the field tag lookup and the command and status bundles
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package sdfe_pkg;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_SP = 8'h20;

    // Length of the "data:" tag and the saturation point of the line counter.
    localparam logic [2:0] PREFIX_LEN   = 3'd5;
    localparam logic [2:0] LINE_POS_MAX = 3'd7;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // a stream byte is taken this cycle
        logic extra_wr;  // write the byte held back behind a pending CR
        logic emit_rd;   // read the next payload byte from the store
        logic emit_ld;   // load the byte just read into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_extra;  // this byte needs a second store write
        logic emit_start;  // this byte is a blank line that ends a non-empty event
        logic emit_last;   // the byte being emitted is the final one
        logic out_free;    // the output register can take a new byte
    } t_dp_sts;

    // Character of the "data:" tag at a given line position.
    function automatic logic [7:0] tag_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = 8'h64;  // d
            3'd1:    c = 8'h61;  // a
            3'd2:    c = 8'h74;  // t
            3'd3:    c = 8'h61;  // a
            3'd4:    c = 8'h3A;  // :
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/sdfe_rx_if.sv =====
// ----------------------------------------------------------------------------
// sdfe_rx_if: stream byte channel
// Valid/ready channel carrying one byte of the event stream per transaction.
// ----------------------------------------------------------------------------
interface sdfe_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== hw/rtl/sdfe_tx_if.sv =====
// ----------------------------------------------------------------------------
// sdfe_tx_if: payload byte channel
// Valid/ready channel carrying one emitted payload byte per transaction.
// ----------------------------------------------------------------------------
interface sdfe_tx_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       last_byte;
    logic       truncated;

    modport source (output valid, output payload_byte, output last_byte,
                    output truncated, input ready);
    modport sink   (input valid, input payload_byte, input last_byte,
                    input truncated, output ready);
endinterface

// ===== hw/rtl/sdfe_ctrl.sv =====
// ----------------------------------------------------------------------------
// sdfe_ctrl: sequencing controller
// Decides when stream bytes are taken, when a held CR costs a second write
// and steps the payload readout one byte at a time.
// ----------------------------------------------------------------------------
module sdfe_ctrl
    import sdfe_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_rx_valid,
    output logic    o_rx_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_RUN,
        S_EXTRA,
        S_EMIT_RD,
        S_EMIT_WR
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_rx_ready = (r_state == S_RUN);

    always_comb begin
        o_cmd.accept   = (r_state == S_RUN) && i_rx_valid;
        o_cmd.extra_wr = (r_state == S_EXTRA);
        o_cmd.emit_rd  = (r_state == S_EMIT_RD);
        o_cmd.emit_ld  = (r_state == S_EMIT_WR) && i_sts.out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_RUN: begin
                if (i_rx_valid) begin
                    if (i_sts.emit_start) begin
                        n_state = S_EMIT_RD;
                    end else if (i_sts.need_extra) begin
                        n_state = S_EXTRA;
                    end
                end
            end
            S_EXTRA: begin
                n_state = S_RUN;
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_WR;
            end
            S_EMIT_WR: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.emit_last ? S_RUN : S_EMIT_RD;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hw/rtl/sdfe_dpath.sv =====
// ----------------------------------------------------------------------------
// sdfe_dpath: line parser datapath
// Holds the line tracking state, the payload store and the output register.
// ----------------------------------------------------------------------------
module sdfe_dpath
    import sdfe_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    output t_dp_sts    o_sts,
    input  logic [7:0] i_rx_byte,
    input  logic       i_tx_ready,
    output logic       o_tx_valid,
    output logic [7:0] o_tx_payload_byte,
    output logic       o_tx_last_byte,
    output logic       o_tx_truncated
);

    localparam int AW = $clog2(PAYLOAD_DEPTH);
    localparam int CW = $clog2(PAYLOAD_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(PAYLOAD_DEPTH);

    logic [7:0]    r_mem [PAYLOAD_DEPTH];
    logic [CW-1:0] r_plen;
    logic [CW-1:0] r_wp;
    logic [2:0]    r_lp;
    logic          r_pm;
    logic          r_dla;
    logic          r_pcr;
    logic          r_ovf;
    logic [7:0]    r_pend;
    logic [CW-1:0] r_rd_idx;
    logic [7:0]    r_rd_data;
    logic          r_out_vld;
    logic [7:0]    r_out_byte;
    logic          r_out_last;
    logic          r_out_trunc;

    logic       is_lf;
    logic       is_cr;
    logic       line_empty;
    logic       store_b;
    logic       tag_hit;
    logic       wr_req;
    logic [7:0] wr_data;
    logic       room;
    logic       wr_en;
    logic       rd_last;

    assign is_lf      = (i_rx_byte == CH_LF);
    assign is_cr      = (i_rx_byte == CH_CR);
    assign line_empty = (r_lp == 3'd0) || ((r_lp == 3'd1) && r_pcr);
    // The single space right after the colon is not part of the payload.
    assign store_b    = !is_cr && !((r_lp == PREFIX_LEN) && (i_rx_byte == CH_SP));
    assign tag_hit    = (r_lp < PREFIX_LEN) && (i_rx_byte == tag_char(r_lp));
    assign room       = (r_wp < DEPTH_C);
    assign wr_en      = wr_req && room;
    assign rd_last    = ((r_rd_idx + CW'(1)) == r_plen);

    always_comb begin
        wr_req  = 1'b0;
        wr_data = i_rx_byte;
        if (i_cmd.extra_wr) begin
            wr_req  = 1'b1;
            wr_data = r_pend;
        end else if (i_cmd.accept && !is_lf && r_dla) begin
            if (r_pcr) begin
                wr_req  = 1'b1;
                wr_data = CH_CR;
            end else if (store_b) begin
                wr_req  = 1'b1;
            end
        end
    end

    always_comb begin
        o_sts.need_extra = !is_lf && r_dla && r_pcr && store_b;
        o_sts.emit_start = is_lf && !r_dla && line_empty && (r_plen != '0);
        o_sts.emit_last  = rd_last;
        o_sts.out_free   = !r_out_vld || i_tx_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen    <= '0;
            r_wp      <= '0;
            r_lp      <= '0;
            r_pm      <= 1'b1;
            r_dla     <= 1'b0;
            r_pcr     <= 1'b0;
            r_ovf     <= 1'b0;
            r_rd_idx  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (wr_en) begin
                r_wp <= r_wp + CW'(1);
            end
            if (wr_req && !room) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.accept) begin
                if (is_lf) begin
                    if (r_dla) begin
                        r_plen <= r_wp;
                    end else if (o_sts.emit_start) begin
                        r_rd_idx <= '0;
                    end
                    r_lp  <= '0;
                    r_pm  <= 1'b1;
                    r_dla <= 1'b0;
                    r_pcr <= 1'b0;
                end else begin
                    if (!r_dla && r_pm) begin
                        if (tag_hit) begin
                            if (r_lp == PREFIX_LEN - 3'd1) begin
                                r_dla <= 1'b1;
                                r_pm  <= 1'b0;
                                r_wp  <= '0;
                                r_ovf <= 1'b0;
                            end
                        end else begin
                            r_pm <= 1'b0;
                        end
                    end
                    r_pcr <= is_cr;
                    if (r_lp < LINE_POS_MAX) begin
                        r_lp <= r_lp + 3'd1;
                    end
                end
            end
            if (i_cmd.emit_ld) begin
                r_rd_idx <= r_rd_idx + CW'(1);
                if (rd_last) begin
                    r_plen <= '0;
                    r_ovf  <= 1'b0;
                end
            end
            if (i_cmd.emit_ld) begin
                r_out_vld <= 1'b1;
            end else if (i_tx_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp[AW-1:0]] <= wr_data;
        end
        if (i_cmd.emit_rd) begin
            r_rd_data <= r_mem[r_rd_idx[AW-1:0]];
        end
        if (i_cmd.accept) begin
            r_pend <= i_rx_byte;
        end
        if (i_cmd.emit_ld) begin
            r_out_byte  <= r_rd_data;
            r_out_last  <= rd_last;
            r_out_trunc <= r_ovf;
        end
    end

    assign o_tx_valid        = r_out_vld;
    assign o_tx_payload_byte = r_out_byte;
    assign o_tx_last_byte    = r_out_last;
    assign o_tx_truncated    = r_out_trunc;

endmodule

// ===== hw/rtl/sse_data_field_extractor.sv =====
// ----------------------------------------------------------------------------
// sse_data_field_extractor: data field extractor for an event stream
// Splits the incoming byte stream into lines and emits the payload of the
// last "data:" line of each event when the event's blank line arrives.
//
//   Channel  Direction  Payload                               Per transaction
//   i_rx     in         rx_byte[7:0]                          one stream byte
//   o_tx     out        payload_byte[7:0], last_byte,         one payload byte
//                       truncated
//
// A stream byte is normally taken at once. A byte other than CR that follows
// a held-back CR inside a data line stalls i_rx, because the CR and the byte
// each need a write through the single write port of the payload store. A
// blank line that ends an event with N payload bytes holds i_rx low for one
// store read and one output load per byte, and while o_tx stalls. The
// output register lets the next stream byte be taken while the final
// payload byte still waits on o_tx. Reset is synchronous and clears all
// line state; the payload store needs no clearing, since only entries
// already written are ever read.
// ----------------------------------------------------------------------------
module sse_data_field_extractor
    import sdfe_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sdfe_rx_if.sink      i_rx,
    sdfe_tx_if.source    o_tx
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // The controller owns the input handshake and the readout sequence.
    sdfe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx.valid),
        .o_rx_ready (i_rx.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // The datapath parses lines, fills the payload store and drives o_tx.
    sdfe_dpath #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_rx_byte         (i_rx.rx_byte),
        .i_tx_ready        (o_tx.ready),
        .o_tx_valid        (o_tx.valid),
        .o_tx_payload_byte (o_tx.payload_byte),
        .o_tx_last_byte    (o_tx.last_byte),
        .o_tx_truncated    (o_tx.truncated)
    );

`ifndef SYNTHESIS
    // Loading a payload byte must present it on the output next cycle.
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit_ld |=> o_tx.valid)
        else $error("loaded payload byte not presented on o_tx");

    // Input is held off while the held-back byte is written.
    a_extra_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.extra_wr |-> !i_rx.ready)
        else $error("stream byte accepted during second store write");

    // A blank line that ends a non-empty event stops the input for readout.
    a_emit_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.accept && w_sts.emit_start) |=> !i_rx.ready)
        else $error("input not stalled at start of payload readout");

    // After the final payload byte is loaded the input is open again.
    a_emit_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit_ld && w_sts.emit_last) |=> i_rx.ready)
        else $error("input not reopened after payload readout");
`endif

endmodule
